// ===== design/mvsm_pkg.sv =====
// Package for the multi-voice stereo mixer: command codes, FSM states, widths.
// No dependencies.
package mvsm_pkg;

  localparam int CMD_W = 3;
  localparam int VID_W = 6;
  localparam int SMP_W = 16;
  localparam int VOL_W = 16;
  localparam int FRM_W = 24;
  localparam int ACC_W = 40;
  localparam int OUT_LIMIT = 32767;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_SET_VOL = 3'd1,
    CMD_FADE    = 3'd2,
    CMD_PLAY    = 3'd3,
    CMD_QUERY   = 3'd4,
    CMD_SAMPLE  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_MIX,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
    logic div_start;
    logic mix;
    logic out_set;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== design/multi_voice_stereo_mixer_with_fades_core.sv =====
// Multi-voice stereo mixer with linear fades, top level.
// A beat passes through the states read, execute, mix and output; out_valid is
// raised in the output state, and a fade step that needs the serial lerp divide
// adds the divide state after execute. One beat in flight; the next beat is
// accepted the cycle after the result is taken.
// Synchronous active-low reset clears voice flags, slot counter and accumulators.
module multi_voice_stereo_mixer_with_fades_core #(
  parameter int VOICES = 64,
  parameter int POSITION_BITS = 24,
  parameter int GAIN_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic [5:0]         in_voice,
  input  logic signed [15:0] in_sample_left,
  input  logic signed [15:0] in_sample_right,
  input  logic               in_last_voice,
  input  logic [15:0]        in_volume_left,
  input  logic [15:0]        in_volume_right,
  input  logic [23:0]        in_fade_frames,
  input  logic [23:0]        in_length_frames,
  input  logic               in_playing_flag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_mix_left,
  output logic signed [15:0] out_mix_right,
  output logic               out_mix_valid,
  output logic [5:0]         out_assigned_voice,
  output logic               out_voice_playing,
  output logic               out_voice_alive,
  output logic               out_slots_full
);
  import mvsm_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  mvsm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .cmd(dcmd), .stat(dstat)
  );

  mvsm_dp #(.VOICES(VOICES), .POSITION_BITS(POSITION_BITS), .GAIN_BITS(GAIN_BITS)) u_dp (
    .clk, .rst_n, .cmd(dcmd), .stat(dstat),
    .in_cmd, .in_voice, .in_sample_left, .in_sample_right, .in_last_voice,
    .in_volume_left, .in_volume_right, .in_fade_frames, .in_length_frames,
    .in_playing_flag,
    .out_mix_left, .out_mix_right, .out_mix_valid, .out_assigned_voice,
    .out_voice_playing, .out_voice_alive, .out_slots_full
  );
endmodule

// ===== design/mvsm_ctrl.sv =====
// Controller FSM for the mixer: sequences read, execute, fade divide, mix, output.
// Depends on mvsm_pkg.
module mvsm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output mvsm_pkg::dp_cmd_t   cmd,
  input  mvsm_pkg::dp_stat_t  stat
);
  import mvsm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = stat.need_div ? ST_DIV : ST_MIX;
      ST_DIV:  if (stat.div_done) state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_READ: cmd.rd = 1'b1;
      ST_EXEC: begin
        cmd.exec = 1'b1;
        cmd.div_start = stat.need_div;
      end
      ST_DIV: ;
      ST_MIX: begin
        cmd.mix = 1'b1;
        cmd.out_set = 1'b1;
      end
      ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== design/mvsm_dp.sv =====
// Datapath for the mixer: voice tables, fade divider, accumulators, result regs.
// Depends on mvsm_pkg.
module mvsm_dp #(
  parameter int VOICES = 64,
  parameter int POSITION_BITS = 24,
  parameter int GAIN_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mvsm_pkg::dp_cmd_t          cmd,
  output mvsm_pkg::dp_stat_t         stat,
  input  logic [2:0]                 in_cmd,
  input  logic [5:0]                 in_voice,
  input  logic signed [15:0]         in_sample_left,
  input  logic signed [15:0]         in_sample_right,
  input  logic                       in_last_voice,
  input  logic [15:0]                in_volume_left,
  input  logic [15:0]                in_volume_right,
  input  logic [23:0]                in_fade_frames,
  input  logic [23:0]                in_length_frames,
  input  logic                       in_playing_flag,
  output logic signed [15:0]         out_mix_left,
  output logic signed [15:0]         out_mix_right,
  output logic                       out_mix_valid,
  output logic [5:0]                 out_assigned_voice,
  output logic                       out_voice_playing,
  output logic                       out_voice_alive,
  output logic                       out_slots_full
);
  import mvsm_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SW = $clog2(VOICES + 1);
  localparam int PB = POSITION_BITS;
  localparam int GB = GAIN_BITS;
  localparam int GF = GB - 2;
  localparam int PW = GB + 17;           // signed product width
  localparam int NW = GB + PB;           // numerator width of fade divide
  localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};

  // voice tables (memories, one registered read port)
  logic [PB-1:0] pos_mem [VOICES];
  logic [PB-1:0] len_mem [VOICES];
  logic [GB-1:0] gl_mem [VOICES], gr_mem [VOICES];
  logic [GB-1:0] fl_mem [VOICES], fr_mem [VOICES];
  logic [GB-1:0] tl_mem [VOICES], tr_mem [VOICES];
  logic [PB-1:0] fb_mem [VOICES], fs_mem [VOICES];
  logic [VOICES-1:0] pos_vld_r, fade_act_r, on_r, live_r;

  // latched beat
  logic [2:0] c_r;
  logic [5:0] v_r;
  logic signed [15:0] sl_r, sr_r;
  logic last_r, pf_r;
  logic [GB-1:0] vl_r, vr_r;
  logic [PB-1:0] ff_r, lf_r;

  logic [SW-1:0] next_slot_r;
  logic signed [ACC_W-1:0] accl_r, accr_r;

  // start outcome captured at exec, before next_slot moves
  logic start_full_r;
  logic [SW-1:0] start_slot_r;

  // read registers
  logic [PB-1:0] pos_q, len_q, fb_q, fs_q;
  logic [GB-1:0] gl_q, gr_q, fl_q, fr_q, tl_q, tr_q;

  logic [VW-1:0] vi, si;
  logic ok;
  assign ok = {3'b0, v_r} < 9'(VOICES);
  assign vi = VW'(v_r);
  assign si = VW'(next_slot_r);

  logic fade_on, on_q, live_q;
  assign fade_on = fade_act_r[vi];
  assign on_q = on_r[vi];
  assign live_q = live_r[vi];

  logic [PB-1:0] pos_eff, d;
  assign pos_eff = pos_vld_r[vi] ? pos_q : '0;
  assign d = pos_eff - fb_q;

  logic mixing;
  assign mixing = (c_r == CMD_SAMPLE) && ok && on_q && live_q && (pos_eff < len_q);

  // fade span passed; need lerp divide otherwise
  logic fade_done;
  logic need_div, div_done;
  assign fade_done = d >= fs_q;
  assign need_div = mixing && fade_on && !fade_done;

  // serial restoring divider, both channels share the loop count
  logic [NW-1:0] nl_r, nr_r, ql, qr;
  logic [PB:0] rl_r, rr_r;
  logic busy_r;
  logic upl_r, upr_r;
  logic [GB-1:0] dfl, dfr;
  assign dfl = (tl_q >= fl_q) ? tl_q - fl_q : fl_q - tl_q;
  assign dfr = (tr_q >= fr_q) ? tr_q - fr_q : fr_q - tr_q;

  // one step for a channel
  logic [PB+1:0] tl_s, tr_s;
  assign tl_s = {rl_r, nl_r[NW-1]} - {2'b0, fs_q};
  assign tr_s = {rr_r, nr_r[NW-1]} - {2'b0, fs_q};

  // k counts NW steps
  localparam int KW = $clog2(NW + 1);
  logic [KW-1:0] k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r <= '0;
    end else if (cmd.div_start) begin
      busy_r <= 1'b1;
      k_r <= KW'(NW);
      nl_r <= NW'(dfl) * NW'(d);
      nr_r <= NW'(dfr) * NW'(d);
      rl_r <= '0;
      rr_r <= '0;
      upl_r <= tl_q >= fl_q;
      upr_r <= tr_q >= fr_q;
    end else if (busy_r) begin
      nl_r <= {nl_r[NW-2:0], ~tl_s[PB+1]};
      nr_r <= {nr_r[NW-2:0], ~tr_s[PB+1]};
      rl_r <= tl_s[PB+1] ? {rl_r[PB-1:0], nl_r[NW-1]} : tl_s[PB:0];
      rr_r <= tr_s[PB+1] ? {rr_r[PB-1:0], nr_r[NW-1]} : tr_s[PB:0];
      k_r <= k_r - 1'b1;
      if (k_r == KW'(1)) busy_r <= 1'b0;
    end
  end
  assign ql = nl_r;
  assign qr = nr_r;
  assign div_done = !busy_r;
  assign stat = {need_div, div_done};

  // fade gain selection
  logic [GB-1:0] gl_new, gr_new;
  always_comb begin
    gl_new = gl_q;
    gr_new = gr_q;
    if (fade_on) begin
      if (fade_done) begin
        gl_new = tl_q;
        gr_new = tr_q;
      end else begin
        gl_new = upl_r ? fl_q + GB'(ql) : fl_q - GB'(ql);
        gr_new = upr_r ? fr_q + GB'(qr) : fr_q - GB'(qr);
      end
    end
  end

  logic signed [PW-1:0] pl, pr;
  assign pl = PW'(sl_r) * $signed({1'b0, gl_new});
  assign pr = PW'(sr_r) * $signed({1'b0, gr_new});

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a, input logic signed [PW-1:0] p);
    logic signed [ACC_W:0] s;
    begin
      s = (ACC_W+1)'(a) + (ACC_W+1)'(p);
      if (s > (ACC_W+1)'(ACC_HI)) sat_add = ACC_HI;
      else if (s < (ACC_W+1)'(ACC_LO)) sat_add = ACC_LO;
      else sat_add = s[ACC_W-1:0];
    end
  endfunction

  function automatic logic [15:0] emit(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-1:0] m;
    logic signed [ACC_W:0] q;
    begin
      m = a[ACC_W-1] ? -a : a;
      q = (ACC_W+1)'(m >> GF);
      if (a[ACC_W-1]) q = -q;
      if (q > (ACC_W+1)'(OUT_LIMIT)) q = (ACC_W+1)'(OUT_LIMIT);
      if (q < -(ACC_W+1)'(OUT_LIMIT)) q = -(ACC_W+1)'(OUT_LIMIT);
      emit = q[15:0];
    end
  endfunction

  logic signed [ACC_W-1:0] accl_m, accr_m;
  assign accl_m = mixing ? sat_add(accl_r, pl) : accl_r;
  assign accr_m = mixing ? sat_add(accr_r, pr) : accr_r;

  logic [PB-1:0] pos_inc;
  assign pos_inc = pos_eff + 1'b1;

  // result beat contents
  logic signed [15:0] mix_l_nxt, mix_r_nxt;
  logic mix_v_nxt, playing_nxt, alive_nxt, full_nxt;
  logic [5:0] slot_nxt;
  logic signed [ACC_W-1:0] accl_nxt, accr_nxt;
  always_comb begin
    mix_l_nxt = '0;
    mix_r_nxt = '0;
    mix_v_nxt = 1'b0;
    slot_nxt = '0;
    playing_nxt = 1'b0;
    alive_nxt = 1'b0;
    full_nxt = 1'b0;
    accl_nxt = accl_m;
    accr_nxt = accr_m;
    case (c_r)
      CMD_START: begin
        full_nxt = start_full_r;
        slot_nxt = start_full_r ? 6'd0 : 6'(start_slot_r);
      end
      CMD_QUERY: if (ok) begin
        playing_nxt = on_q;
        alive_nxt = live_q;
      end
      CMD_SAMPLE: if (last_r) begin
        mix_l_nxt = emit(accl_m);
        mix_r_nxt = emit(accr_m);
        mix_v_nxt = 1'b1;
        accl_nxt = '0;
        accr_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r <= in_cmd; v_r <= in_voice;
      sl_r <= in_sample_left; sr_r <= in_sample_right;
      last_r <= in_last_voice; pf_r <= in_playing_flag;
      vl_r <= GB'(in_volume_left); vr_r <= GB'(in_volume_right);
      ff_r <= PB'(in_fade_frames); lf_r <= PB'(in_length_frames);
    end
    if (cmd.rd) begin
      pos_q <= pos_mem[vi]; len_q <= len_mem[vi];
      gl_q <= gl_mem[vi]; gr_q <= gr_mem[vi];
      fl_q <= fl_mem[vi]; fr_q <= fr_mem[vi];
      tl_q <= tl_mem[vi]; tr_q <= tr_mem[vi];
      fb_q <= fb_mem[vi]; fs_q <= fs_mem[vi];
    end
    if (cmd.exec) begin
      case (c_r)
        CMD_START: if (next_slot_r < SW'(VOICES)) begin
          len_mem[si] <= lf_r; gl_mem[si] <= vl_r; gr_mem[si] <= vl_r;
        end
        CMD_SET_VOL: if (ok) begin
          gl_mem[vi] <= vl_r; gr_mem[vi] <= vr_r;
        end
        CMD_FADE: if (ok) begin
          fl_mem[vi] <= gl_q; fr_mem[vi] <= gr_q;
          tl_mem[vi] <= vl_r; tr_mem[vi] <= vr_r;
          fb_mem[vi] <= pos_eff; fs_mem[vi] <= ff_r;
        end
        default: ;
      endcase
    end
    if (cmd.mix && mixing) begin
      gl_mem[vi] <= gl_new; gr_mem[vi] <= gr_new;
      pos_mem[vi] <= pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r <= '0; fade_act_r <= '0; on_r <= '0; live_r <= '0;
      next_slot_r <= '0; accl_r <= '0; accr_r <= '0;
      out_mix_left <= '0; out_mix_right <= '0; out_mix_valid <= 1'b0;
      out_assigned_voice <= '0; out_voice_playing <= 1'b0;
      out_voice_alive <= 1'b0; out_slots_full <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (c_r)
          CMD_START: if (next_slot_r < SW'(VOICES)) begin
            pos_vld_r[si] <= 1'b0; fade_act_r[si] <= 1'b0;
            on_r[si] <= 1'b1; live_r[si] <= 1'b1;
            next_slot_r <= next_slot_r + 1'b1;
          end
          CMD_SET_VOL: if (ok) fade_act_r[vi] <= 1'b0;
          CMD_FADE:    if (ok) fade_act_r[vi] <= 1'b1;
          CMD_PLAY:    if (ok) on_r[vi] <= pf_r;
          default: ;
        endcase
      end
      if (cmd.mix && (c_r == CMD_SAMPLE) && ok && on_q && live_q) begin
        if (!mixing || pos_inc >= len_q) begin
          on_r[vi] <= 1'b0; live_r[vi] <= 1'b0;
        end
        if (mixing) begin
          pos_vld_r[vi] <= 1'b1;
          if (fade_on && fade_done) fade_act_r[vi] <= 1'b0;
        end
      end
      if (cmd.out_set) begin
        out_mix_left <= mix_l_nxt; out_mix_right <= mix_r_nxt;
        out_mix_valid <= mix_v_nxt;
        out_assigned_voice <= slot_nxt; out_voice_playing <= playing_nxt;
        out_voice_alive <= alive_nxt; out_slots_full <= full_nxt;
        accl_r <= accl_nxt; accr_r <= accr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      start_full_r <= next_slot_r >= SW'(VOICES);
      start_slot_r <= next_slot_r;
    end
  end
endmodule
